// File: hw/rtl/ura_pkg.sv
// Shared types, constants and helpers for the ultrasonic range tone alarm.
`timescale 1ns / 1ps

package ura_pkg;

    // Sizing of the echo timer and the distance fixed-point format
    localparam int TIMER_BITS     = 16;
    localparam int DIST_FRAC_BITS = 8;

    // Fixed field widths
    localparam int STAMP_W  = 16;
    localparam int LIMIT_W  = 8;
    localparam int DIST_W   = 24;
    localparam int FREQ_W   = 13;
    localparam int PERIOD_W = 20;
    localparam int HIGH_W   = 19;

    // width * 17000 / 32768, scaled by 2^DIST_FRAC_BITS
    localparam int SPEED_FACTOR = 17000;
    localparam int SPEED_W      = 15;
    localparam int TICK_SHIFT   = 15 - DIST_FRAC_BITS;
    localparam int PROD_D_W     = TIMER_BITS + SPEED_W;
    localparam int DIST_CMP_W   = ((PROD_D_W > DIST_W) ? PROD_D_W : DIST_W) + 1;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Tone line: 111 Hz per cm
    localparam int SLOPE       = 111;
    localparam int SLOPE_W     = 7;
    localparam int RISE_OFFSET = 555;
    localparam int FALL_OFFSET = 5555;
    localparam int FREQ_MAX    = 5555;
    localparam int PROD_T_W    = DIST_W + SLOPE_W;
    localparam int TONE_W      = PROD_T_W + 2;

    // Tone period = 1000000 / frequency
    localparam int PERIOD_NUM = 1000000;
    localparam int DIV_CNT_W  = $clog2(PERIOD_W + 1);
    localparam int DIV_STEPS  = PERIOD_W;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEAR     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MID      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAR      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TONE_MIN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TONE_MAX = 3'd4;

    // Configuration reset values
    localparam logic [LIMIT_W-1:0] NEAR_RESET     = 8'd10;
    localparam logic [LIMIT_W-1:0] MID_RESET      = 8'd30;
    localparam logic [LIMIT_W-1:0] FAR_RESET      = 8'd50;
    localparam logic [LIMIT_W-1:0] TONE_MIN_RESET = 8'd5;
    localparam logic [LIMIT_W-1:0] TONE_MAX_RESET = 8'd50;

    typedef struct packed {
        logic [STAMP_W-1:0] capture_time;
        logic               button_held;
    } capture_t;

    typedef struct packed {
        logic               led_red;
        logic               led_green;
        logic [DIST_W-1:0]  distance_q8;
        logic [FREQ_W-1:0]  tone_frequency;
        logic [PERIOD_W-1:0] tone_period;
        logic [HIGH_W-1:0]  tone_high_time;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture transaction accepted
        logic mul_dist;   // echo width times speed factor
        logic set_dist;   // scale and saturate distance
        logic mul_tone;   // distance times slope, zone compare
        logic set_tone;   // frequency, divider init
        logic div_step;   // one quotient bit
        logic publish;    // load the result register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;   // result register can take a new transaction
    } dp_status_t;

    // Whole-cm limit to the fixed-point distance format
    function automatic logic [DIST_W-1:0] limit_q(input logic [LIMIT_W-1:0] lim);
        limit_q = DIST_W'(lim) << DIST_FRAC_BITS;
    endfunction

endpackage

// File: hw/rtl/ura_ctrl.sv
// Sequencing controller for the range tone alarm.
`timescale 1ns / 1ps

module ura_ctrl
    import ura_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       capture_valid,
    output logic       capture_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_DIST,
        S_SET_DIST,
        S_MUL_TONE,
        S_SET_TONE,
        S_DIV,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [DIV_CNT_W-1:0]   count_reg, count_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (capture_valid)
                begin
                    state_next = S_MUL_DIST;
                end
            end
            S_MUL_DIST: state_next = S_SET_DIST;
            S_SET_DIST: state_next = S_MUL_TONE;
            S_MUL_TONE: state_next = S_SET_TONE;
            S_SET_TONE:
            begin
                count_next = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                count_next = count_reg + 1'b1;
                if (count_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Commands decoded from state
    assign capture_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.load     = (state_reg == S_IDLE) && capture_valid;
        cmd.mul_dist = (state_reg == S_MUL_DIST);
        cmd.set_dist = (state_reg == S_SET_DIST);
        cmd.mul_tone = (state_reg == S_MUL_TONE);
        cmd.set_tone = (state_reg == S_SET_TONE);
        cmd.div_step = (state_reg == S_DIV);
        cmd.publish  = (state_reg == S_DONE) && status.out_free;
    end

endmodule

// File: hw/rtl/ura_datapath.sv
// Datapath: echo state, distance, zones, tone, period divider, result register.
`timescale 1ns / 1ps

module ura_datapath
    import ura_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  capture_t               capture,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [LIMIT_W-1:0]     cfg_data,
    input  logic                   result_stall,
    output logic                   result_valid,
    output result_t                result,
    input  dp_cmd_t                cmd,
    output dp_status_t             status
);

    // Configuration registers
    logic [LIMIT_W-1:0] near_reg, mid_reg, far_reg, tmin_reg, tmax_reg;

    // Echo state
    logic                  awaiting_reg;
    logic [STAMP_W-1:0]    start_reg;
    logic [DIST_W-1:0]     dist_reg;

    // Working registers
    logic                  is_end_reg;
    logic                  held_reg;
    logic [TIMER_BITS-1:0] width_reg;
    logic [PROD_D_W-1:0]   prod_d_reg;
    logic [PROD_T_W-1:0]   prod_t_reg;
    logic                  in_range_reg;
    logic                  red_reg, green_reg;
    logic [FREQ_W-1:0]     freq_reg;
    logic [PERIOD_W-1:0]   quo_reg;
    logic [FREQ_W-1:0]     rem_reg;

    // Result register
    logic                  out_valid_reg;
    result_t               out_reg;

    // Combinational helpers
    logic [PROD_D_W-1:0]   dist_full;
    logic [DIST_W-1:0]     dist_sat;
    logic signed [TONE_W-1:0] tone_raw;
    logic signed [TONE_W-1:0] tone_q;
    logic [FREQ_W-1:0]     freq_calc;
    logic [FREQ_W:0]       rem_shift;
    logic                  quo_bit;
    logic [PERIOD_W-1:0]   period_out;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg <= NEAR_RESET;
            mid_reg  <= MID_RESET;
            far_reg  <= FAR_RESET;
            tmin_reg <= TONE_MIN_RESET;
            tmax_reg <= TONE_MAX_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NEAR:     near_reg <= cfg_data;
                CFG_MID:      mid_reg  <= cfg_data;
                CFG_FAR:      far_reg  <= cfg_data;
                CFG_TONE_MIN: tmin_reg <= cfg_data;
                CFG_TONE_MAX: tmax_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Edge pairing and stored distance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b0;
            start_reg    <= '0;
            dist_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                awaiting_reg <= !awaiting_reg;
                if (!awaiting_reg)
                begin
                    start_reg <= capture.capture_time;
                end
            end
            if (cmd.set_dist && is_end_reg)
            begin
                dist_reg <= dist_sat;
            end
        end
    end

    // Distance scaling and saturation
    always_comb
    begin
        dist_full = prod_d_reg >> TICK_SHIFT;
        if (DIST_CMP_W'(dist_full) > DIST_CMP_W'(DIST_MAX))
        begin
            dist_sat = DIST_MAX;
        end
        else
        begin
            dist_sat = DIST_W'(dist_full);
        end
    end

    // Tone line, clamp and saturation
    always_comb
    begin
        if (held_reg)
        begin
            tone_raw = $signed({2'b00, prod_t_reg})
                     - $signed(TONE_W'(RISE_OFFSET) << DIST_FRAC_BITS);
        end
        else
        begin
            tone_raw = $signed(TONE_W'(FALL_OFFSET) << DIST_FRAC_BITS)
                     - $signed({2'b00, prod_t_reg});
        end
        tone_q = tone_raw >>> DIST_FRAC_BITS;
        if (!in_range_reg || tone_raw <= 0)
        begin
            freq_calc = '0;
        end
        else if (tone_q > $signed(TONE_W'(FREQ_MAX)))
        begin
            freq_calc = FREQ_W'(FREQ_MAX);
        end
        else
        begin
            freq_calc = FREQ_W'(tone_q);
        end
    end

    // Restoring divider step
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[PERIOD_W-1]};
        quo_bit   = (rem_shift >= {1'b0, freq_reg});
    end

    // Working pipeline of the sequencer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            is_end_reg <= awaiting_reg;
            held_reg   <= capture.button_held;
            width_reg  <= TIMER_BITS'(capture.capture_time - start_reg);
        end
        if (cmd.mul_dist)
        begin
            prod_d_reg <= PROD_D_W'(width_reg) * PROD_D_W'(SPEED_FACTOR);
        end
        if (cmd.mul_tone)
        begin
            prod_t_reg   <= PROD_T_W'(dist_reg) * PROD_T_W'(SLOPE);
            in_range_reg <= !(dist_reg < limit_q(tmin_reg)) && !(dist_reg > limit_q(tmax_reg));
            if (dist_reg < limit_q(near_reg))
            begin
                red_reg   <= 1'b1;
                green_reg <= 1'b1;
            end
            else if (dist_reg < limit_q(mid_reg))
            begin
                red_reg   <= 1'b1;
                green_reg <= 1'b0;
            end
            else if (dist_reg < limit_q(far_reg))
            begin
                red_reg   <= 1'b0;
                green_reg <= 1'b1;
            end
            else
            begin
                red_reg   <= 1'b0;
                green_reg <= 1'b0;
            end
        end
        if (cmd.set_tone)
        begin
            freq_reg <= freq_calc;
            quo_reg  <= PERIOD_W'(PERIOD_NUM);
            rem_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[PERIOD_W-2:0], quo_bit};
            // remainder stays below the divisor, so it fits in FREQ_W bits
            rem_reg <= FREQ_W'(quo_bit ? (rem_shift - {1'b0, freq_reg}) : rem_shift);
        end
    end

    // Silent tone has zero period
    assign period_out = (freq_reg == '0) ? '0 : quo_reg;

    // Result register, one transaction deep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_reg.led_red        <= red_reg;
            out_reg.led_green      <= green_reg;
            out_reg.distance_q8    <= dist_reg;
            out_reg.tone_frequency <= freq_reg;
            out_reg.tone_period    <= period_out;
            out_reg.tone_high_time <= HIGH_W'(period_out >> 1);
        end
    end

    assign result_valid    = out_valid_reg;
    assign result          = out_reg;
    assign status.out_free = !out_valid_reg || !result_stall;

endmodule

// File: hw/rtl/ultrasonic_range_tone_alarm_unit.sv
// An accepted capture steps through distance multiply, distance set, tone multiply, tone set,
// the 20-step restoring period divider and done, where it is published if the result register is free.
// A new capture is taken while the previous result still waits in the output register.
// Reset (rst_n low, asynchronous) clears the edge pairing, start stamp and distance,
// drops result_valid and loads the default limits 10/30/50/5/50 cm.
`timescale 1ns / 1ps

module ultrasonic_range_tone_alarm_unit
    import ura_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   capture_valid,
    output logic                   capture_stall,
    input  capture_t               capture,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [LIMIT_W-1:0]     cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    ura_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .capture_valid (capture_valid),
        .capture_stall (capture_stall),
        .status        (status),
        .cmd           (cmd)
    );

    ura_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .capture      (capture),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .cmd          (cmd),
        .status       (status)
    );

endmodule
